/* hw/rtl/jbeq_pkg.sv */
// ----------------------------------------------------------------------------
// jbeq_pkg
// shared types, key and kind codes, and event slot tables for the qualifier
// ----------------------------------------------------------------------------
package jbeq_pkg;

  // key codes, also used for the held joystick direction
  localparam logic [2:0] KEY_UP    = 3'd0;
  localparam logic [2:0] KEY_DOWN  = 3'd1;
  localparam logic [2:0] KEY_LEFT  = 3'd2;
  localparam logic [2:0] KEY_RIGHT = 3'd3;
  localparam logic [2:0] KEY_OK    = 3'd4;
  localparam logic [2:0] KEY_BACK  = 3'd5;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_SHORT   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;

  localparam int          THRESH_W          = 12;
  localparam int          DEB_W             = 3;
  localparam int          SEQ_W             = 32;
  localparam logic [11:0] LOW_THRESH_RESET  = 12'd1200;
  localparam logic [11:0] HIGH_THRESH_RESET = 12'd2800;
  localparam logic [2:0]  DEBOUNCE_RESET    = 3'd3;

  // history entries reset to mid scale
  localparam int MID_W        = 12;
  localparam int SAMPLE_MID   = 2048;

  // event slots of one tick, in emission order
  localparam int NUM_SLOTS  = 9;
  localparam int SLOT_IDX_W = 4;
  localparam int EV_JREL    = 0;
  localparam int EV_JPRESS  = 1;
  localparam int EV_JSHORT  = 2;
  localparam int EV_BPRESS  = 3;
  localparam int EV_BSHORT  = 4;
  localparam int EV_BREL    = 5;
  localparam int EV_OPRESS  = 6;
  localparam int EV_OSHORT  = 7;
  localparam int EV_OREL    = 8;

  // job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  typedef struct packed {
    logic [THRESH_W-1:0] low_threshold;
    logic [THRESH_W-1:0] high_threshold;
    logic [DEB_W-1:0]    debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] ev_mask;
    logic [2:0]           rel_key;
    logic [2:0]           dir_key;
    logic [SEQ_W-1:0]     seq_base;
  } job_t;

  function automatic logic [1:0] slot_kind(input logic [SLOT_IDX_W-1:0] slot);
    logic [1:0] k;
    case (slot)
      4'(EV_JREL):   k = KIND_RELEASE;
      4'(EV_JPRESS): k = KIND_PRESS;
      4'(EV_JSHORT): k = KIND_SHORT;
      4'(EV_BPRESS): k = KIND_PRESS;
      4'(EV_BSHORT): k = KIND_SHORT;
      4'(EV_BREL):   k = KIND_RELEASE;
      4'(EV_OPRESS): k = KIND_PRESS;
      4'(EV_OSHORT): k = KIND_SHORT;
      4'(EV_OREL):   k = KIND_RELEASE;
      default:       k = KIND_PRESS;
    endcase
    return k;
  endfunction

  // the sequence number advances after the last slot of each group
  function automatic logic group_end(input logic [SLOT_IDX_W-1:0] slot);
    logic e;
    case (slot)
      4'(EV_JREL), 4'(EV_JSHORT), 4'(EV_BREL), 4'(EV_OREL): e = 1'b1;
      default: e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

/* hw/rtl/jbeq_ifs.sv */
// ----------------------------------------------------------------------------
// jbeq channel interfaces
// poll tick, event and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface jbeq_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic                   back_level;
  logic                   ok_level;

  modport source (output valid, sample_x, sample_y, back_level, ok_level, input ready);
  modport sink   (input valid, sample_x, sample_y, back_level, ok_level, output ready);
endinterface

interface jbeq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_key;
  logic [1:0]  event_kind;
  logic [31:0] event_sequence;
  logic        last_event;

  modport source (output valid, event_key, event_kind, event_sequence, last_event,
                  input ready);
  modport sink   (input valid, event_key, event_kind, event_sequence, last_event,
                  output ready);
endinterface

interface jbeq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/jbeq_front.sv */
// ----------------------------------------------------------------------------
// jbeq_front
// averages, direction classification and button debounce, at most one job per tick
// ----------------------------------------------------------------------------
module jbeq_front #(
  parameter int AVG_DEPTH   = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  jbeq_in_if.sink       poll,
  input  jbeq_pkg::cfg_t cfg_regs,
  output logic          push_valid,
  output jbeq_pkg::job_t push_job,
  input  logic          push_ready
);
  import jbeq_pkg::*;

  localparam int HIST_W  = (SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W;
  localparam int SUM_W   = HIST_W + $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SH      = SUM_W + 4;
  localparam longint RECIP = ((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef struct packed {
    logic             last;
    logic             acc;
    logic [DEB_W-1:0] cnt;
  } btn_t;

  function automatic btn_t btn_step(input btn_t cur, input logic pressed,
                                    input logic [DEB_W-1:0] db);
    btn_t nx;
    nx = cur;
    if (pressed == cur.last) begin
      if (cur.cnt < db) nx.cnt = cur.cnt + 3'd1;
    end else begin
      nx.last = pressed;
      nx.cnt  = 3'd1;
    end
    if (nx.cnt >= db && cur.acc != nx.last) nx.acc = nx.last;
    return nx;
  endfunction

  logic              adv;
  logic              take;
  logic [HIST_W-1:0] ring_x [AVG_DEPTH];
  logic [HIST_W-1:0] ring_y [AVG_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_y;
  logic [HIST_W-1:0] new_x;
  logic [HIST_W-1:0] new_y;
  btn_t              back_st, ok_st, back_next, ok_next;
  logic              back_press, ok_press;

  logic              s1_valid, s1_back, s1_ok;
  logic              s2_valid, s2_back, s2_ok;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [HIST_W-1:0] avg_x, avg_y;

  logic [2:0]        held;
  logic [2:0]        dir;
  logic [SEQ_W-1:0]  seq;
  logic              rel_ev, prs_ev;
  logic [2:0]        groups;
  logic [HIST_W-1:0] low_thr, high_thr;

  assign take  = poll.valid && adv;
  assign new_x = HIST_W'(poll.sample_x);
  assign new_y = HIST_W'(poll.sample_y);

  // debounce, pressed means pin low
  always_comb begin
    back_next  = btn_step(back_st, !poll.back_level, cfg_regs.debounce_ticks);
    ok_next    = btn_step(ok_st, !poll.ok_level, cfg_regs.debounce_ticks);
    back_press = back_next.acc && !back_st.acc;
    ok_press   = ok_next.acc && !ok_st.acc;
  end

  // stage 1: history ring and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_x[i] <= HIST_W'(SAMPLE_MID);
        ring_y[i] <= HIST_W'(SAMPLE_MID);
      end
      sum_x    <= SUM_W'(AVG_DEPTH * SAMPLE_MID);
      sum_y    <= SUM_W'(AVG_DEPTH * SAMPLE_MID);
      slot     <= '0;
      back_st  <= '0;
      ok_st    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        ring_x[slot] <= new_x;
        ring_y[slot] <= new_y;
        sum_x   <= sum_x - SUM_W'(ring_x[slot]) + SUM_W'(new_x);
        sum_y   <= sum_y - SUM_W'(ring_y[slot]) + SUM_W'(new_y);
        slot    <= (slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot + 1'b1;
        back_st <= back_next;
        ok_st   <= ok_next;
      end
      if (adv) s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_back <= back_press;
      s1_ok   <= ok_press;
    end
  end

  // stage 2: average by reciprocal multiply
  assign prod_x = PROD_W'(sum_x) * PROD_W'(RECIP_W'(RECIP));
  assign prod_y = PROD_W'(sum_y) * PROD_W'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      avg_x   <= prod_x[SH +: HIST_W];
      avg_y   <= prod_y[SH +: HIST_W];
      s2_back <= s1_back;
      s2_ok   <= s1_ok;
    end
  end

  // stage 3: direction, job build and sequence allocation
  always_comb begin
    low_thr  = HIST_W'(cfg_regs.low_threshold);
    high_thr = HIST_W'(cfg_regs.high_threshold);
    if (avg_x < low_thr)       dir = KEY_LEFT;
    else if (avg_x > high_thr) dir = KEY_RIGHT;
    else if (avg_y < low_thr)  dir = KEY_UP;
    else if (avg_y > high_thr) dir = KEY_DOWN;
    else                       dir = DIR_NONE;
    rel_ev = (dir != held) && (held != DIR_NONE);
    prs_ev = (dir != held) && (dir != DIR_NONE);
    groups = 3'(rel_ev) + 3'(prs_ev) + 3'(s2_back) + 3'(s2_ok);

    push_job = '0;
    push_job.ev_mask[EV_JREL]   = rel_ev;
    push_job.ev_mask[EV_JPRESS] = prs_ev;
    push_job.ev_mask[EV_JSHORT] = prs_ev;
    push_job.ev_mask[EV_BPRESS] = s2_back;
    push_job.ev_mask[EV_BSHORT] = s2_back;
    push_job.ev_mask[EV_BREL]   = s2_back;
    push_job.ev_mask[EV_OPRESS] = s2_ok;
    push_job.ev_mask[EV_OSHORT] = s2_ok;
    push_job.ev_mask[EV_OREL]   = s2_ok;
    push_job.rel_key  = held;
    push_job.dir_key  = dir;
    push_job.seq_base = seq;
  end

  assign push_valid = s2_valid && (|push_job.ev_mask);
  assign adv        = !push_valid || push_ready;
  assign poll.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= DIR_NONE;
      seq  <= '0;
    end else if (s2_valid && adv) begin
      held <= dir;
      seq  <= seq + SEQ_W'(groups);
    end
  end

endmodule

/* hw/rtl/jbeq_fifo.sv */
// ----------------------------------------------------------------------------
// jbeq_fifo
// short job queue decoupling the front from the event sequencer
// ----------------------------------------------------------------------------
module jbeq_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  jbeq_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output jbeq_pkg::job_t pop_data
);
  import jbeq_pkg::*;

  job_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_fire, pop_fire;

  assign push_ready = (count != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= wr_ptr + 1'b1;
      if (pop_fire)  rd_ptr <= rd_ptr + 1'b1;
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push_fire && !pop_fire |=> count == $past(count) + 3'd1)
    else $error("queue count did not rise on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop_fire && !push_fire |=> count == $past(count) - 3'd1)
    else $error("queue count did not fall on pop");

endmodule

/* hw/rtl/jbeq_back.sv */
// ----------------------------------------------------------------------------
// jbeq_back
// event sequencer: walks the slots of one job into registered event words
// ----------------------------------------------------------------------------
module jbeq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  jbeq_pkg::job_t pop_job,
  jbeq_out_if.source     events
);
  import jbeq_pkg::*;

  logic                  busy;
  logic [NUM_SLOTS-1:0]  rem;
  logic [NUM_SLOTS-1:0]  rem_next;
  logic [2:0]            rel_key;
  logic [2:0]            dir_key;
  logic [SEQ_W-1:0]      seq;
  logic [SLOT_IDX_W-1:0] cur;
  logic [2:0]            cur_key;
  logic                  load;
  logic                  pop_fire;

  assign pop_ready = !busy;
  assign pop_fire  = pop_valid && pop_ready;
  assign load      = !events.valid || events.ready;
  assign rem_next  = rem & (rem - 1'b1);

  // lowest pending slot
  always_comb begin
    cur = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) cur = SLOT_IDX_W'(i);
    end
    if (cur == SLOT_IDX_W'(EV_JREL))                   cur_key = rel_key;
    else if (cur <= SLOT_IDX_W'(EV_JSHORT))            cur_key = dir_key;
    else if (cur <= SLOT_IDX_W'(EV_BREL))              cur_key = KEY_BACK;
    else                                               cur_key = KEY_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      rem          <= '0;
      events.valid <= 1'b0;
    end else begin
      if (pop_fire) begin
        busy <= 1'b1;
        rem  <= pop_job.ev_mask;
      end else if (busy && load) begin
        rem  <= rem_next;
        busy <= (rem_next != '0);
      end
      if (load) events.valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      rel_key <= pop_job.rel_key;
      dir_key <= pop_job.dir_key;
      seq     <= pop_job.seq_base;
    end else if (busy && load) begin
      seq <= seq + SEQ_W'(group_end(cur));
    end
    if (busy && load) begin
      events.event_key      <= cur_key;
      events.event_kind     <= slot_kind(cur);
      events.event_sequence <= seq;
      events.last_event     <= (rem_next == '0);
    end
  end

  a_busy_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop_fire |=> busy)
    else $error("sequencer not busy after taking a job");

  a_busy_has_slots: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("sequencer busy with no pending slot");

endmodule

/* hw/rtl/joystick_button_event_qualifier.sv */
// ----------------------------------------------------------------------------
// joystick_button_event_qualifier
// joystick averaging, direction events and debounced button events
// ----------------------------------------------------------------------------
//  channel  role      words
//  poll     sink      one poll tick: two samples and two active-low buttons
//  events   source    one key event: key, kind, sequence, last of tick
//  cfg      sink      register write: index and data, always ready
//
//  a tick passes the front's stage 1 and stage 2 registers before it reaches
//  the job queue; the front takes a tick every cycle while the queue has room
//  the sequencer emits one event word per cycle while the output is not
//  stalled, and takes the next job only after the last word of the current one
//  reset clears history to mid scale, direction to none, buttons to released
//  a stalled event output holds its word; the queue lets ticks keep arriving
// ----------------------------------------------------------------------------
module joystick_button_event_qualifier #(
  parameter int AVG_DEPTH   = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  jbeq_in_if.sink     poll,
  jbeq_out_if.source  events,
  jbeq_cfg_if.sink    cfg
);
  import jbeq_pkg::*;

  cfg_t cfg_regs;
  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // configuration registers, writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.low_threshold  <= LOW_THRESH_RESET;
      cfg_regs.high_threshold <= HIGH_THRESH_RESET;
      cfg_regs.debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOW_THRESHOLD:  cfg_regs.low_threshold  <= cfg.data;
        REG_HIGH_THRESHOLD: cfg_regs.high_threshold <= cfg.data;
        REG_DEBOUNCE_TICKS: cfg_regs.debounce_ticks <= cfg.data[DEB_W-1:0];
        default:            cfg_regs <= cfg_regs;  // unknown index ignored
      endcase
    end
  end

  // front: ring averages, direction and debounce, at most one job word per tick
  jbeq_front #(
    .AVG_DEPTH   (AVG_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll),
    .cfg_regs   (cfg_regs),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // job queue, ticks without events never enter it
  jbeq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  // back: serialises each job into event words
  jbeq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .events    (events)
  );

endmodule

/* tb/sv/joystick_button_event_qualifier_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_button_event_qualifier_tb
// self-checking bench: poll words go in, key event words come out and are
// compared field by field against a predictor built into a scoreboard class
// ----------------------------------------------------------------------------
module joystick_button_event_qualifier_tb;
  import jbeq_pkg::*;

  localparam int AVG_DEPTH     = 4;
  localparam int SAMPLE_BITS   = 12;
  localparam int PHASE_WORDS   = 26;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_WORDS    = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_GAP       = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  key;
    logic [1:0]  kind;
    logic [31:0] seq;
    logic        last;
  } key_event_t;

  // predictor of the event stream plus the queue of event words still owed
  class key_event_scoreboard;
    logic [11:0] low_thr;
    logic [11:0] high_thr;
    logic [2:0]  deb_ticks;
    logic [11:0] x_hist[AVG_DEPTH];
    logic [11:0] y_hist[AVG_DEPTH];
    int          slot;
    logic [2:0]  held_dir;
    logic [31:0] seq_num;
    logic        last_raw[2];
    logic        accepted[2];
    logic [2:0]  stable[2];
    key_event_t  owed_events[$];
    int          errors;

    function new();
      low_thr   = LOW_THRESH_RESET;
      high_thr  = HIGH_THRESH_RESET;
      deb_ticks = DEBOUNCE_RESET;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        x_hist[i] = 12'(SAMPLE_MID);
        y_hist[i] = 12'(SAMPLE_MID);
      end
      slot     = 0;
      held_dir = DIR_NONE;
      seq_num  = '0;
      for (int b = 0; b < 2; b++) begin
        last_raw[b] = 1'b0;
        accepted[b] = 1'b0;
        stable[b]   = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOW_THRESHOLD:  low_thr = data;
        REG_HIGH_THRESHOLD: high_thr = data;
        REG_DEBOUNCE_TICKS: deb_ticks = data[2:0];
        default: ;
      endcase
    endfunction

    function void owe_event(logic [2:0] key, logic [1:0] kind);
      key_event_t e;
      e.key  = key;
      e.kind = kind;
      e.seq  = seq_num;
      e.last = 1'b0;
      owed_events.push_back(e);
    endfunction

    // saturating stability counter; only a qualified press makes events
    function void button_step(int b, logic pressed, logic [2:0] key);
      if (pressed == last_raw[b]) begin
        if (stable[b] < deb_ticks) stable[b] = stable[b] + 3'd1;
      end else begin
        last_raw[b] = pressed;
        stable[b]   = 3'd1;
      end
      if (stable[b] >= deb_ticks && accepted[b] != last_raw[b]) begin
        accepted[b] = last_raw[b];
        if (accepted[b]) begin
          owe_event(key, KIND_PRESS);
          owe_event(key, KIND_SHORT);
          owe_event(key, KIND_RELEASE);
          seq_num++;
        end
      end
    endfunction

    function void note_poll_tick(logic [11:0] x, logic [11:0] y, logic back_lvl,
                                 logic ok_lvl);
      int unsigned sum_x;
      int unsigned sum_y;
      int unsigned avg_x;
      int unsigned avg_y;
      logic [2:0]  dir;
      int          first;
      first        = owed_events.size();
      x_hist[slot] = x;
      y_hist[slot] = y;
      slot         = (slot + 1) % AVG_DEPTH;
      sum_x        = 0;
      sum_y        = 0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        sum_x += x_hist[i];
        sum_y += y_hist[i];
      end
      avg_x = sum_x / AVG_DEPTH;
      avg_y = sum_y / AVG_DEPTH;
      if (avg_x < low_thr) dir = KEY_LEFT;
      else if (avg_x > high_thr) dir = KEY_RIGHT;
      else if (avg_y < low_thr) dir = KEY_UP;
      else if (avg_y > high_thr) dir = KEY_DOWN;
      else dir = DIR_NONE;
      if (dir != held_dir) begin
        if (held_dir != DIR_NONE) begin
          owe_event(held_dir, KIND_RELEASE);
          seq_num++;
        end
        if (dir != DIR_NONE) begin
          owe_event(dir, KIND_PRESS);
          owe_event(dir, KIND_SHORT);
          seq_num++;
        end
        held_dir = dir;
      end
      button_step(0, !back_lvl, KEY_BACK);
      button_step(1, !ok_lvl, KEY_OK);
      if (owed_events.size() > first) owed_events[$].last = 1'b1;
    endfunction

    function void check_key_event(logic [2:0] key, logic [1:0] kind, logic [31:0] seq,
                                  logic last);
      key_event_t e;
      if (owed_events.size() == 0) begin
        $error("unexpected event word: key %0d kind %0d seq %0d", key, kind, seq);
        errors++;
        return;
      end
      e = owed_events.pop_front();
      if (key !== e.key) begin
        $error("event_key mismatch: expected %0d, actual %0d", e.key, key);
        errors++;
      end
      if (kind !== e.kind) begin
        $error("event_kind mismatch: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (seq !== e.seq) begin
        $error("event_sequence mismatch: expected %0d, actual %0d", e.seq, seq);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_event mismatch: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_events.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  jbeq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) poll_if ();
  jbeq_out_if                             ev_if ();
  jbeq_cfg_if                             cfg_if ();

  joystick_button_event_qualifier #(
    .AVG_DEPTH   (AVG_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_if),
    .events (ev_if),
    .cfg    (cfg_if)
  );

  key_event_scoreboard sb;

  // idling knobs, set per phase by the stimulus process
  int send_idle_pct;
  int recv_stall_pct;
  // poll valid currently raised by the sender
  bit poll_offered;

  // long receiver hold-off: the stimulus bumps hold_req, the receiver counts
  int hold_req;
  int hold_seen;
  int hold_left;

  // random stimulus state: joystick target held for a run of ticks, buttons
  // held at a level for a run, with the odd glitch and noise word in between
  logic [11:0] stick_x;
  logic [11:0] stick_y;
  int          stick_left;
  logic        back_hold;
  int          back_left;
  logic        ok_hold;
  int          ok_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous hard limit on the whole run
  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random back-pressure, long hold-off on request, and checking
  always @(posedge clk) begin
    if (!rst && ev_if.valid && ev_if.ready)
      sb.check_key_event(ev_if.event_key, ev_if.event_kind, ev_if.event_sequence,
                         ev_if.last_event);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one poll word, after an optional idle gap, and wait for acceptance
  task automatic send_poll_tick(input logic [11:0] x, input logic [11:0] y,
                                input logic back_lvl, input logic ok_lvl);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (poll_offered) poll_if.valid <= 1'b0;
      poll_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_if.valid      <= 1'b1;
    poll_if.sample_x   <= x;
    poll_if.sample_y   <= y;
    poll_if.back_level <= back_lvl;
    poll_if.ok_level   <= ok_lvl;
    poll_offered = 1'b1;
    @(posedge clk);
    while (!poll_if.ready) @(posedge clk);
    sb.note_poll_tick(x, y, back_lvl, ok_lvl);
  endtask

  task automatic poll_stop();
    if (poll_offered) poll_if.valid <= 1'b0;
    poll_offered = 1'b0;
  endtask

  // always steps the clock before checking, so a raise never meets a lower
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // a tick with no events may still be in flight once the queue is empty
  task automatic settle();
    poll_stop();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // all three registers plus the unused index, valid held high throughout
  task automatic program_regs(input logic [11:0] low, input logic [11:0] high,
                              input logic [2:0] deb);
    cfg_write(REG_LOW_THRESHOLD, low);
    cfg_write(REG_HIGH_THRESHOLD, high);
    cfg_write(REG_DEBOUNCE_TICKS, {9'($urandom), deb});
    cfg_write(REG_UNUSED, 12'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(5))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return 12'($urandom_range(0, 1100));
      3:       return 12'($urandom_range(2900, 4095));
      4:       return 12'($urandom_range(1300, 2700));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_random_tick();
    logic [11:0] x;
    logic [11:0] y;
    logic        b;
    logic        o;
    if (stick_left == 0) begin
      stick_x    = pick_sample();
      stick_y    = pick_sample();
      stick_left = $urandom_range(1, 8);
    end
    stick_left--;
    if (back_left == 0) begin
      back_hold = ~back_hold;
      back_left = $urandom_range(1, 10);
    end
    back_left--;
    if (ok_left == 0) begin
      ok_hold = ~ok_hold;
      ok_left = $urandom_range(1, 10);
    end
    ok_left--;
    x = stick_x;
    y = stick_y;
    b = back_hold;
    o = ok_hold;
    // noise word: fully random samples
    if ($urandom_range(99) < 12) begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    // single-tick contact bounce
    if ($urandom_range(99) < 8) b = ~b;
    if ($urandom_range(99) < 8) o = ~o;
    send_poll_tick(x, y, b, o);
  endtask

  initial begin
    sb = new();
    rst                = 1'b1;
    poll_if.valid      = 1'b0;
    poll_if.sample_x   = '0;
    poll_if.sample_y   = '0;
    poll_if.back_level = 1'b1;
    poll_if.ok_level   = 1'b1;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    ev_if.ready        = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    poll_offered       = 1'b0;
    hold_req           = 0;
    hold_seen          = 0;
    hold_left          = 0;
    stick_left         = 0;
    back_hold          = 1'b1;
    back_left          = 0;
    ok_hold            = 1'b1;
    ok_left            = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    settle();

    // directed, reset register values: each direction from the sample
    // extremes, left winning over up, both buttons pressed and released
    repeat (3) send_poll_tick(12'd0, 12'd2048, 1'b1, 1'b1);
    repeat (3) send_poll_tick(12'hFFF, 12'd2048, 1'b0, 1'b1);
    repeat (3) send_poll_tick(12'd2048, 12'd0, 1'b1, 1'b0);
    repeat (3) send_poll_tick(12'd2048, 12'hFFF, 1'b0, 1'b0);
    repeat (3) send_poll_tick(12'd0, 12'd0, 1'b1, 1'b1);
    // ok bounce too short to qualify
    send_poll_tick(12'd2048, 12'd2048, 1'b1, 1'b0);
    send_poll_tick(12'd2048, 12'd2048, 1'b1, 1'b1);

    // debounce of zero, thresholds meeting at mid scale: hold left, then a
    // single word moves left to up while both buttons press, the fullest tick
    settle();
    program_regs(12'd2048, 12'd2048, 3'd0);
    repeat (4) send_poll_tick(12'd2047, 12'd0, 1'b1, 1'b1);
    send_poll_tick(12'd2051, 12'd0, 1'b0, 1'b0);

    // crossed thresholds, longest debounce
    settle();
    program_regs(12'd3000, 12'd1000, 3'd7);
    send_poll_tick(12'd2048, 12'd2048, 1'b1, 1'b1);
    send_poll_tick(12'd3500, 12'd500, 1'b0, 1'b1);
    send_poll_tick(12'd500, 12'd3500, 1'b0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       program_regs(12'd0, 12'hFFF, 3'd7);
        1:       program_regs(12'hFFF, 12'd0, 3'd1);
        2:       program_regs(LOW_THRESH_RESET, HIGH_THRESH_RESET, DEBOUNCE_RESET);
        3:       program_regs(12'd2048, 12'd2048, 3'd0);
        default: program_regs(12'($urandom_range(0, 2047)), 12'($urandom_range(2048, 4095)),
                              3'($urandom_range(0, 7)));
      endcase
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
      // receiver goes quiet while words keep coming, so the block backs up
      if (p == 0) begin
        hold_req <= hold_req + 1;
        repeat (HOLD_WORDS) send_random_tick();
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // sender pauses mid-phase until every owed event has arrived
        if (p == 1 && i == PHASE_WORDS / 2) begin
          poll_stop();
          wait_drained();
        end
        send_random_tick();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/jbeq_pkg.sv
hw/rtl/jbeq_ifs.sv
hw/rtl/jbeq_front.sv
hw/rtl/jbeq_fifo.sv
hw/rtl/jbeq_back.sv
hw/rtl/joystick_button_event_qualifier.sv
tb/sv/joystick_button_event_qualifier_tb.sv
